### rtl/core/trv_pkg.sv
// ----------------------------------------------------------------------------
// trv_pkg
// Shared types, character codes and helpers for the trivia gap scanner.
// ----------------------------------------------------------------------------
package trv_pkg;

    // span kinds
    localparam logic [1:0] KIND_WS    = 2'd0;
    localparam logic [1:0] KIND_LINE  = 2'd1;
    localparam logic [1:0] KIND_BLOCK = 2'd2;

    // character codes
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_STAR  = 8'h2a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0b;
    localparam logic [7:0] CH_FF    = 8'h0c;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // result queue depth
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    typedef struct packed {
        logic [1:0]  span_kind;
        logic [31:0] span_start;
        logic [31:0] span_end;
        logic        scan_error;
        logic        last_of_run;
    } result_t;

    // results caused by one item, handed from scanner to queue
    typedef struct packed {
        logic [1:0] cnt;
        result_t    r0;
        result_t    r1;
    } push_t;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_VT) ||
               (b == CH_FF) || (b == CH_CR) || (b == CH_LF);
    endfunction

    function automatic result_t mk_result(input logic [1:0] kind,
                                          input logic [31:0] s,
                                          input logic [31:0] e,
                                          input logic err);
        result_t r;
        r.span_kind   = kind;
        r.span_start  = s;
        r.span_end    = e;
        r.scan_error  = err;
        r.last_of_run = 1'b0;
        return r;
    endfunction

endpackage

### rtl/core/trv_if.sv
// ----------------------------------------------------------------------------
// trv_if
// Handshake channels: gap bytes in, trivia spans out.
// ----------------------------------------------------------------------------
interface trv_byte_if;
    logic        valid;
    logic        ready;
    logic [7:0]  gap_byte;
    logic [31:0] byte_offset;
    logic        gap_end;

    modport source (output valid, gap_byte, byte_offset, gap_end, input ready);
    modport sink   (input valid, gap_byte, byte_offset, gap_end, output ready);
endinterface

interface trv_span_if;
    logic        valid;
    logic        ready;
    logic [1:0]  span_kind;
    logic [31:0] span_start;
    logic [31:0] span_end;
    logic        scan_error;
    logic        last_of_run;

    modport source (output valid, span_kind, span_start, span_end, scan_error,
                    last_of_run, input ready);
    modport sink   (input valid, span_kind, span_start, span_end, scan_error,
                    last_of_run, output ready);
endinterface

### rtl/core/trivia_gap_scanner.sv
// ----------------------------------------------------------------------------
// trivia_gap_scanner
// Splits inter-token gaps into whitespace, line comment and block comment
// spans, flagging bytes that are not trivia.
//
//   channel | dir | payload                                          | kind
//   gap     | in  | gap_byte, byte_offset, gap_end                   | valid/ready
//   span    | out | span_kind, span_start, span_end, scan_error,     | valid/ready
//           |     | last_of_run                                      |
//
// One byte per cycle sustained while the result queue has room; a byte
// waits in the input register until the queue has room, then its results
// are written to the queue. A byte giving two results hands them out one
// at a time; the 4-entry result queue accepts a new byte whenever two
// slots are free. Reset clears scanner state, input valid and queue pointers.
// A stalled output holds its head result; input stalls below two free slots.
// ----------------------------------------------------------------------------
module trivia_gap_scanner
    import trv_pkg::*;
#(
    parameter int OFFSET_BITS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    trv_byte_if.sink   gap,
    trv_span_if.source span
);

    push_t push;
    logic  room;

    // scanner
    trv_scan_core #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .gap   (gap),
        .room  (room),
        .push  (push)
    );

    // result queue
    trv_result_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .room  (room),
        .span  (span)
    );

endmodule

### rtl/core/trv_scan_core.sv
// ----------------------------------------------------------------------------
// trv_scan_core
// Input register and scanner state machine; emits up to two results per item.
// ----------------------------------------------------------------------------
module trv_scan_core
    import trv_pkg::*;
#(
    parameter int OFFSET_BITS = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    trv_byte_if.sink       gap,
    input  logic           room,
    output push_t          push
);

    localparam int OW = (OFFSET_BITS < 32) ? OFFSET_BITS : 32;
    localparam logic [OW-1:0] OFS_ONE = OW'(1);

    localparam logic [2:0] MODE_IDLE       = 3'd0;
    localparam logic [2:0] MODE_WS         = 3'd1;
    localparam logic [2:0] MODE_SLASH      = 3'd2;
    localparam logic [2:0] MODE_LINE       = 3'd3;
    localparam logic [2:0] MODE_BLOCK      = 3'd4;
    localparam logic [2:0] MODE_BLOCK_STAR = 3'd5;

    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    logic [OW-1:0] in_off_reg;
    logic          in_last_reg;

    logic [2:0]    mode_reg, mode_next;
    logic [OW-1:0] start_reg, start_next;
    logic          err_reg, err_next;

    logic          fire;
    logic [OW-1:0] off_inc;
    logic [31:0]   off32, inc32, start32;
    logic [1:0]    res_cnt;
    result_t       res [2];

    assign fire      = in_valid_reg && room;
    assign gap.ready = !in_valid_reg || room;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (gap.valid && gap.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (gap.valid && gap.ready)
        begin
            in_byte_reg <= gap.gap_byte;
            in_off_reg  <= gap.byte_offset[OW-1:0];
            in_last_reg <= gap.gap_end;
        end
    end

    // scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            start_reg <= '0;
            err_reg   <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            start_reg <= start_next;
            err_reg   <= err_next;
        end
    end

    assign off_inc = in_off_reg + OFS_ONE;
    assign off32   = 32'(in_off_reg);
    assign inc32   = 32'(off_inc);

    // next state and results for the registered item
    always_comb
    begin
        mode_next  = mode_reg;
        start_next = start_reg;
        err_next   = err_reg;
        res_cnt    = 2'd0;
        res[0]     = '0;
        res[1]     = '0;
        start32    = 32'(start_reg);

        if (!err_reg)
        begin
            unique case (mode_reg)
                MODE_WS:
                begin
                    if (!is_ws(in_byte_reg))
                    begin
                        res[res_cnt[0]] = mk_result(KIND_WS, start32, off32, 1'b0);
                        res_cnt = res_cnt + 2'd1;
                        if (in_byte_reg == CH_SLASH)
                        begin
                            mode_next  = MODE_SLASH;
                            start_next = in_off_reg;
                        end
                        else
                        begin
                            res[res_cnt[0]] = mk_result(KIND_WS, off32, off32, 1'b1);
                            res_cnt   = res_cnt + 2'd1;
                            err_next  = 1'b1;
                            mode_next = MODE_IDLE;
                        end
                    end
                end
                MODE_SLASH:
                begin
                    if (in_byte_reg == CH_SLASH)
                    begin
                        mode_next = MODE_LINE;
                    end
                    else if (in_byte_reg == CH_STAR)
                    begin
                        mode_next = MODE_BLOCK;
                    end
                    else
                    begin
                        res[res_cnt[0]] = mk_result(KIND_WS, off32, off32, 1'b1);
                        res_cnt   = res_cnt + 2'd1;
                        err_next  = 1'b1;
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_LINE:
                begin
                    if (in_byte_reg == CH_CR || in_byte_reg == CH_LF)
                    begin
                        res[res_cnt[0]] = mk_result(KIND_LINE, start32, off32, 1'b0);
                        res_cnt    = res_cnt + 2'd1;
                        mode_next  = MODE_WS;
                        start_next = in_off_reg;
                    end
                end
                MODE_BLOCK:
                begin
                    if (in_byte_reg == CH_STAR)
                    begin
                        mode_next = MODE_BLOCK_STAR;
                    end
                end
                MODE_BLOCK_STAR:
                begin
                    if (in_byte_reg == CH_SLASH)
                    begin
                        res[res_cnt[0]] = mk_result(KIND_BLOCK, start32, inc32, 1'b0);
                        res_cnt   = res_cnt + 2'd1;
                        mode_next = MODE_IDLE;
                    end
                    else if (in_byte_reg != CH_STAR)
                    begin
                        mode_next = MODE_BLOCK;
                    end
                end
                default:
                begin
                    // no span open: start one or flag the byte
                    mode_next = MODE_IDLE;
                    if (is_ws(in_byte_reg))
                    begin
                        mode_next  = MODE_WS;
                        start_next = in_off_reg;
                    end
                    else if (in_byte_reg == CH_SLASH)
                    begin
                        mode_next  = MODE_SLASH;
                        start_next = in_off_reg;
                    end
                    else
                    begin
                        res[res_cnt[0]] = mk_result(KIND_WS, off32, off32, 1'b1);
                        res_cnt  = res_cnt + 2'd1;
                        err_next = 1'b1;
                    end
                end
            endcase
        end

        // close the gap
        if (in_last_reg)
        begin
            if (!err_next)
            begin
                if (mode_next == MODE_WS)
                begin
                    res[res_cnt[0]] = mk_result(KIND_WS, 32'(start_next), inc32, 1'b0);
                    res_cnt = res_cnt + 2'd1;
                end
                else if (mode_next == MODE_LINE)
                begin
                    res[res_cnt[0]] = mk_result(KIND_LINE, 32'(start_next), inc32, 1'b0);
                    res_cnt = res_cnt + 2'd1;
                end
                else if (mode_next != MODE_IDLE)
                begin
                    res[res_cnt[0]] = mk_result(KIND_WS, off32, off32, 1'b1);
                    res_cnt = res_cnt + 2'd1;
                end
            end
            mode_next  = MODE_IDLE;
            start_next = '0;
            err_next   = 1'b0;
        end

        // mark the final result of this item
        if (res_cnt == 2'd1)
        begin
            res[0].last_of_run = 1'b1;
        end
        else if (res_cnt == 2'd2)
        begin
            res[1].last_of_run = 1'b1;
        end
    end

    assign push.cnt = fire ? res_cnt : 2'd0;
    assign push.r0  = res[0];
    assign push.r1  = res[1];

    // bytes after an error inside a gap produce nothing
    a_quiet_after_error: assert property (@(posedge clk) disable iff (!rst_n)
        fire && err_reg && !in_last_reg |-> push.cnt == 2'd0)
        else $error("result emitted after latched error");

    // a gap end always leaves the scanner idle and clean
    a_idle_after_gap: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_last_reg |=> mode_reg == MODE_IDLE && !err_reg && start_reg == '0)
        else $error("state not cleared at gap end");

    // exactly the final result carries last_of_run
    a_last_marked: assert property (@(posedge clk) disable iff (!rst_n)
        push.cnt == 2'd2 |-> !push.r0.last_of_run && push.r1.last_of_run)
        else $error("last_of_run misplaced");

endmodule

### rtl/core/trv_result_fifo.sv
// ----------------------------------------------------------------------------
// trv_result_fifo
// Small result queue: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
module trv_result_fifo
    import trv_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  push_t          push,
    output logic           room,
    trv_span_if.source     span
);

    localparam logic [RES_CNT_W-1:0] CNT_ROOM = RES_CNT_W'(RES_DEPTH - 2);
    localparam logic [RES_CNT_W-1:0] CNT_FULL = RES_CNT_W'(RES_DEPTH);

    result_t                mem_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [RES_PTR_W-1:0]   wr_ptr_inc;
    logic [RES_CNT_W-1:0]   count_reg, count_next;
    logic                   pop;
    result_t                head;

    assign room       = (count_reg <= CNT_ROOM);
    assign pop        = span.valid && span.ready;
    assign wr_ptr_inc = wr_ptr_reg + RES_PTR_W'(1);
    assign count_next = count_reg + RES_CNT_W'(push.cnt) - RES_CNT_W'(pop);

    // storage
    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.cnt == 2'd2)
        begin
            mem_reg[wr_ptr_inc] <= push.r1;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + RES_PTR_W'(push.cnt);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + RES_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    assign head             = mem_reg[rd_ptr_reg];
    assign span.valid       = (count_reg != '0);
    assign span.span_kind   = head.span_kind;
    assign span.span_start  = head.span_start;
    assign span.span_end    = head.span_end;
    assign span.scan_error  = head.scan_error;
    assign span.last_of_run = head.last_of_run;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("result queue overflow");

    // scanner only pushes when two slots are free
    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.cnt != 2'd0 |-> count_reg <= CNT_ROOM)
        else $error("push without room");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> count_reg == $past(count_reg) + RES_CNT_W'($past(push.cnt))
                             - RES_CNT_W'(1))
        else $error("fill count mismatch");

endmodule

### tb/sv/trivia_span_checker.sv
// ----------------------------------------------------------------------------
// trivia_span_checker
// Watches the gap and span channels of the trivia gap scanner. Each accepted
// gap byte is run through a local scanner model; the spans it should produce
// are queued and compared field by field against the spans the block emits.
// ----------------------------------------------------------------------------
module trivia_span_checker
    import trv_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    trv_byte_if  gap,
    trv_span_if  span,
    output int   fail_count,
    output int   expect_depth
);

    // local scanner state
    typedef enum logic [2:0] {
        SC_IDLE,
        SC_WS,
        SC_SLASH,
        SC_LINE,
        SC_BLOCK,
        SC_BLOCK_STAR
    } scan_state_t;

    scan_state_t scan_st;
    logic [31:0] open_start;
    logic        err_hold;

    // spans caused by the current byte, and spans still owed by the block
    result_t step_out[$];
    result_t spans_due[$];

    function automatic logic blank_char(input logic [7:0] b);
        case (b)
            CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR, CH_LF: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    task automatic add_span(input logic [1:0] kind, input logic [31:0] s,
                            input logic [31:0] e, input logic err);
        result_t r;
        r.span_kind   = kind;
        r.span_start  = s;
        r.span_end    = e;
        r.scan_error  = err;
        r.last_of_run = 1'b0;
        step_out.push_back(r);
    endtask

    // error span sits on the offending byte; rest of the gap is dropped
    task automatic flag_error(input logic [31:0] off);
        add_span(KIND_WS, off, off, 1'b1);
        err_hold = 1'b1;
        scan_st  = SC_IDLE;
    endtask

    // byte arriving with no span open
    task automatic open_span(input logic [7:0] b, input logic [31:0] off);
        if (blank_char(b))
        begin
            scan_st    = SC_WS;
            open_start = off;
        end
        else if (b == CH_SLASH)
        begin
            scan_st    = SC_SLASH;
            open_start = off;
        end
        else
        begin
            flag_error(off);
        end
    endtask

    // advance the scanner by one byte and queue the spans it causes
    task automatic scan_gap_byte(input logic [7:0] b, input logic [31:0] off,
                                 input logic fin);
        logic [31:0] past;
        past = off + 32'd1;
        step_out.delete();
        if (!err_hold)
        begin
            case (scan_st)
                SC_WS:
                begin
                    if (!blank_char(b))
                    begin
                        add_span(KIND_WS, open_start, off, 1'b0);
                        scan_st = SC_IDLE;
                        open_span(b, off);
                    end
                end
                SC_SLASH:
                begin
                    if (b == CH_SLASH)
                        scan_st = SC_LINE;
                    else if (b == CH_STAR)
                        scan_st = SC_BLOCK;
                    else
                        flag_error(off);
                end
                SC_LINE:
                begin
                    // a line break ends the comment and opens a whitespace run
                    if (b == CH_CR || b == CH_LF)
                    begin
                        add_span(KIND_LINE, open_start, off, 1'b0);
                        scan_st    = SC_WS;
                        open_start = off;
                    end
                end
                SC_BLOCK:
                begin
                    if (b == CH_STAR)
                        scan_st = SC_BLOCK_STAR;
                end
                SC_BLOCK_STAR:
                begin
                    if (b == CH_SLASH)
                    begin
                        add_span(KIND_BLOCK, open_start, past, 1'b0);
                        scan_st = SC_IDLE;
                    end
                    else if (b != CH_STAR)
                    begin
                        scan_st = SC_BLOCK;
                    end
                end
                default:
                begin
                    scan_st = SC_IDLE;
                    open_span(b, off);
                end
            endcase
        end

        // gap end closes whatever is open
        if (fin)
        begin
            if (!err_hold)
            begin
                if (scan_st == SC_WS)
                    add_span(KIND_WS, open_start, past, 1'b0);
                else if (scan_st == SC_LINE)
                    add_span(KIND_LINE, open_start, past, 1'b0);
                else if (scan_st != SC_IDLE)
                    flag_error(off);
            end
            scan_st    = SC_IDLE;
            open_start = '0;
            err_hold   = 1'b0;
        end

        if (step_out.size() != 0)
            step_out[step_out.size() - 1].last_of_run = 1'b1;
        foreach (step_out[i])
            spans_due.push_back(step_out[i]);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic match_span();
        result_t want;
        if (spans_due.size() == 0)
        begin
            $error("span_start: expected no span, got %0h", span.span_start);
            fail_count++;
        end
        else
        begin
            want = spans_due.pop_front();
            check_field("span_kind", 32'(want.span_kind), 32'(span.span_kind));
            check_field("span_start", want.span_start, span.span_start);
            check_field("span_end", want.span_end, span.span_end);
            check_field("scan_error", 32'(want.scan_error), 32'(span.scan_error));
            check_field("last_of_run", 32'(want.last_of_run), 32'(span.last_of_run));
        end
    endtask

    // sample both channels on the clock
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_st    = SC_IDLE;
            open_start = '0;
            err_hold   = 1'b0;
            fail_count = 0;
            spans_due.delete();
            expect_depth <= 0;
        end
        else
        begin
            if (gap.valid && gap.ready)
                scan_gap_byte(gap.gap_byte, gap.byte_offset, gap.gap_end);
            if (span.valid && span.ready)
                match_span();
            expect_depth <= spans_due.size();
        end
    end

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives gaps of bytes into the trivia gap scanner: a directed set of corner
// gaps, then random gaps built mostly from well-formed whitespace and comment
// pieces with some noise. Input and output sides idle at random, with one
// long output hold-off and drain pauses on the input side.
// ----------------------------------------------------------------------------
module tb_top
    import trv_pkg::*;
();

    localparam int RANDOM_ITEMS = 1680;
    localparam int HOLD_AFTER   = 400;
    localparam int HOLD_CYCLES  = 300;
    localparam int PAUSE_AFTER  = 900;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 8;

    typedef struct packed {
        logic [7:0]  b;
        logic [31:0] off;
        logic        fin;
    } gap_item_t;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   expect_depth;
    int   sent_cnt;
    int   n_directed;
    int   cycle_cnt;

    gap_item_t  byte_plan[$];
    logic [7:0] gap_buf[$];

    trv_byte_if gap_ch();
    trv_span_if span_ch();

    trivia_gap_scanner #(
        .OFFSET_BITS(32)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .gap   (gap_ch),
        .span  (span_ch)
    );

    trivia_span_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .gap          (gap_ch),
        .span         (span_ch),
        .fail_count   (fail_count),
        .expect_depth (expect_depth)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // gap building helpers
    task automatic put(input logic [7:0] b);
        gap_buf.push_back(b);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            gap_buf.push_back(s[i]);
    endtask

    // turn the buffered bytes into one gap; offsets may jump when scattered
    task automatic seal_gap(input logic [31:0] base, input logic scatter);
        gap_item_t   it;
        logic [31:0] cur;
        cur = base;
        foreach (gap_buf[i])
        begin
            it.b   = gap_buf[i];
            it.off = cur;
            it.fin = (i == gap_buf.size() - 1);
            byte_plan.push_back(it);
            cur = cur + 32'd1;
            if (scatter && $urandom_range(0, 19) == 0)
                cur = $urandom;
        end
        gap_buf.delete();
    endtask

    function automatic logic [7:0] blank_byte();
        case ($urandom_range(0, 5))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_VT;
            3: return CH_FF;
            4: return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    // comment body bytes lean toward star and slash
    function automatic logic [7:0] comment_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return CH_STAR;
        else if (r < 40)
            return CH_SLASH;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic put_block_body();
        logic [7:0] c;
        logic [7:0] prev;
        prev = 8'h00;
        repeat ($urandom_range(0, 6))
        begin
            c = comment_byte();
            // no early close inside a well-formed body
            if (prev == CH_STAR && c == CH_SLASH)
                c = CH_STAR;
            put(c);
            prev = c;
        end
    endtask

    task automatic build_random_gap();
        int          pieces;
        int          pick;
        logic [7:0]  c;
        logic [31:0] base;
        pieces = $urandom_range(1, 4);
        for (int p = 0; p < pieces; p++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                repeat ($urandom_range(1, 5))
                    put(blank_byte());
            end
            else if (pick < 55)
            begin
                put(CH_SLASH);
                put(CH_SLASH);
                repeat ($urandom_range(0, 6))
                begin
                    c = comment_byte();
                    if (c == CH_CR || c == CH_LF)
                        c = 8'h78;
                    put(c);
                end
                if (p != pieces - 1 || $urandom_range(0, 1))
                    put(($urandom_range(0, 1)) ? CH_CR : CH_LF);
            end
            else if (pick < 80)
            begin
                put(CH_SLASH);
                put(CH_STAR);
                put_block_body();
                put(CH_STAR);
                put(CH_SLASH);
            end
            else if (pick < 88)
            begin
                // lone slash, optionally followed by a byte that opens nothing
                put(CH_SLASH);
                if ($urandom_range(0, 3) != 0)
                begin
                    do
                        c = 8'($urandom_range(0, 255));
                    while (c == CH_SLASH || c == CH_STAR);
                    put(c);
                end
            end
            else if (pick < 94)
            begin
                // unclosed block comment runs to the gap end
                put(CH_SLASH);
                put(CH_STAR);
                put_block_body();
                break;
            end
            else
            begin
                put(8'($urandom_range(0, 255)));
            end
        end
        if ($urandom_range(0, 9) == 0)
            base = 32'hFFFF_FFFF - 32'($urandom_range(0, 8));
        else
            base = $urandom;
        seal_gap(base, 1'b1);
    endtask

    task automatic build_directed();
        // single blank byte at the top offset, end wraps
        put(CH_SPACE);
        seal_gap(32'hFFFF_FFFF, 1'b0);
        // lone slash at the gap end
        put(CH_SLASH);
        seal_gap(32'h0000_0000, 1'b0);
        // slash followed by a plain byte
        put_text("/x");
        seal_gap(32'd100, 1'b0);
        // line comment ended by a line break, which opens whitespace
        put_text("//a");
        put(CH_LF);
        seal_gap(32'd200, 1'b0);
        // opener star does not close the comment, so it stays unclosed
        put_text("/*/");
        seal_gap(32'd300, 1'b0);
        put_text("/**/");
        seal_gap(32'd400, 1'b0);
        // whitespace then a bad byte; bytes after the error are ignored
        put(CH_TAB);
        put_text("A");
        put(8'hFF);
        put(CH_SPACE);
        seal_gap(32'd500, 1'b0);
        put(CH_VT);
        put(CH_FF);
        put(CH_CR);
        seal_gap(32'd600, 1'b0);
        // line comment closed by the gap end, end wraps
        put_text("//");
        seal_gap(32'hFFFF_FFFE, 1'b0);
        put(8'h00);
        seal_gap(32'h5555_AAAA, 1'b0);
    endtask

    // wait until the block owes no spans
    task automatic drain();
        gap_ch.valid <= 1'b0;
        @(posedge clk);
        while (expect_depth != 0)
            @(posedge clk);
    endtask

    // sender: bursts of bytes separated by random idle stretches
    initial
    begin : sender
        int        burst_left;
        int        idle_len;
        gap_item_t it;
        rst_n              <= 1'b0;
        gap_ch.valid       <= 1'b0;
        gap_ch.gap_byte    <= '0;
        gap_ch.byte_offset <= '0;
        gap_ch.gap_end     <= 1'b0;
        sent_cnt   = 0;
        burst_left = 0;
        build_directed();
        n_directed = byte_plan.size();
        while (byte_plan.size() < n_directed + RANDOM_ITEMS)
            build_random_gap();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int idx = 0; idx < byte_plan.size(); idx++)
        begin
            if (idx == n_directed || idx == n_directed + PAUSE_AFTER)
            begin
                drain();
                burst_left = 0;
            end
            if (burst_left == 0)
            begin
                idle_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (idle_len > 0)
                begin
                    gap_ch.valid <= 1'b0;
                    repeat (idle_len) @(posedge clk);
                end
                burst_left = $urandom_range(1, 24);
            end
            it = byte_plan[idx];
            gap_ch.valid       <= 1'b1;
            gap_ch.gap_byte    <= it.b;
            gap_ch.byte_offset <= it.off;
            gap_ch.gap_end     <= it.fin;
            @(posedge clk);
            while (!gap_ch.ready)
                @(posedge clk);
            burst_left--;
            sent_cnt++;
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("trivia_gap_scanner: match");
        else
            $display("trivia_gap_scanner: mismatch");
        $finish;
    end

    // receiver: stall style is picked anew when its run ends, one long hold-off
    initial
    begin : receiver
        int   style;
        int   style_left;
        logic hold_done;
        span_ch.ready <= 1'b0;
        style      = 0;
        style_left = 0;
        hold_done  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!hold_done && sent_cnt >= n_directed + HOLD_AFTER)
            begin
                span_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            if (style_left == 0)
            begin
                style      = $urandom_range(0, 2);
                style_left = $urandom_range(16, 96);
            end
            style_left--;
            case (style)
                0: span_ch.ready <= 1'b1;
                1: span_ch.ready <= 1'($urandom_range(0, 1));
                default: span_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // run limit
    initial
    begin : watchdog
        cycle_cnt = 0;
        forever
        begin
            @(posedge clk);
            cycle_cnt++;
            if (cycle_cnt > CYCLE_LIMIT)
            begin
                $display("trivia_gap_scanner: mismatch");
                $finish;
            end
        end
    end

endmodule
